### design/tbtc_pkg.sv
// ----------------------------------------------------------------------------
// tbtc_pkg
// Shared types, codes and helpers of the track block traffic controller.
// ----------------------------------------------------------------------------
package tbtc_pkg;

    typedef struct packed {
        logic        command;
        logic        occupied;
        logic [13:0] loco_address;
        logic [9:0]  loco_speed;
        logic [1:0]  loco_dir;
        logic        sensor_cw;
        logic        sensor_ccw;
        logic [1:0]  next_cw_status;
        logic [13:0] next_cw_reserver;
        logic [1:0]  next_ccw_status;
        logic [13:0] next_ccw_reserver;
        logic [1:0]  reserve_sens;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  traffic_state;
        logic [3:0]  detected_event;
        logic [1:0]  network_dir;
        logic        cmd_valid;
        logic [9:0]  cmd_speed;
        logic [1:0]  cmd_dir;
        logic [13:0] cmd_address;
    } t_out_item;

    typedef struct packed {
        logic [9:0] max_speed;
        logic [9:0] brake_speed;
        logic [7:0] speed_margin;
        logic [9:0] resv_timeout;
    } t_cfg;

    // input commands
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESERVE = 1'b1;

    // events
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_BUSY_ON    = 4'd1;
    localparam logic [3:0] EV_BUSY_OFF   = 4'd2;
    localparam logic [3:0] EV_IDENTIFIED = 4'd3;
    localparam logic [3:0] EV_OVER_LIMIT = 4'd4;
    localparam logic [3:0] EV_SPEED_OK   = 4'd5;
    localparam logic [3:0] EV_NEXT_BUSY  = 4'd6;
    localparam logic [3:0] EV_BRAKE      = 4'd7;
    localparam logic [3:0] EV_STOP       = 4'd8;
    localparam logic [3:0] EV_DANGEROUS  = 4'd9;

    // travel direction
    localparam logic [1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [1:0] DIR_CW      = 2'd1;
    localparam logic [1:0] DIR_CCW     = 2'd2;
    localparam logic [1:0] DIR_INVALID = 2'd3;

    // drive direction
    localparam logic [1:0] LDIR_FWD = 2'd1;
    localparam logic [1:0] LDIR_REV = 2'd2;

    // next block status
    localparam logic [1:0] NB_ABSENT = 2'd0;
    localparam logic [1:0] NB_BUSY   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_SPEED    = 2'd0;
    localparam logic [1:0] CFG_BRAKE_SPEED  = 2'd1;
    localparam logic [1:0] CFG_SPEED_TOL    = 2'd2;
    localparam logic [1:0] CFG_RESV_TIMEOUT = 2'd3;

    localparam logic [9:0]  MOVING_THRESHOLD  = 10'd20;
    localparam logic [9:0]  DEFAULT_TARGET    = 10'd1000;
    localparam logic [9:0]  RST_MAX_SPEED     = 10'd1000;
    localparam logic [9:0]  RST_BRAKE_SPEED   = 10'd200;
    localparam logic [7:0]  RST_SPEED_TOL     = 8'd20;
    localparam logic [9:0]  RST_RESV_TIMEOUT  = 10'd15;
    localparam logic [13:0] ADDR_KNOWN_MIN    = 14'd2;

    function automatic logic close_speeds(input logic [9:0] a, input logic [9:0] b,
                                          input logic [7:0] tol);
        logic [9:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= {2'b00, tol};
    endfunction

endpackage

### design/tbtc_in_if.sv
// ----------------------------------------------------------------------------
// tbtc_in_if
// Input channel: one tick or reservation beat per handshake.
// ----------------------------------------------------------------------------
interface tbtc_in_if;
    logic               valid;
    logic               ready;
    tbtc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/tbtc_out_if.sv
// ----------------------------------------------------------------------------
// tbtc_out_if
// Result channel: one result beat per handshake.
// ----------------------------------------------------------------------------
interface tbtc_out_if;
    logic                valid;
    logic                ready;
    tbtc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/tbtc_ctrl.sv
// ----------------------------------------------------------------------------
// tbtc_ctrl
// Block state registers and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module tbtc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  tbtc_pkg::t_in_item  i_item,
    input  tbtc_pkg::t_cfg      i_cfg,
    output tbtc_pkg::t_out_item o_result
);

    typedef enum logic [3:0] {
        ST_FREE        = 4'd0,
        ST_RESERVED    = 4'd1,
        ST_OCC_UNKNOWN = 4'd2,
        ST_OCC_KNOWN   = 4'd3,
        ST_RUNNING     = 4'd4,
        ST_LIMITED     = 4'd5,
        ST_SLOWING     = 4'd6,
        ST_STOPPING    = 4'd7,
        ST_STOPPED     = 4'd8
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_tdir, n_tdir;
    logic [9:0]  r_last, n_last;
    logic [13:0] r_held, n_held;
    logic [1:0]  r_hdir, n_hdir;
    logic [13:0] r_rtrain, n_rtrain;
    logic [1:0]  r_rdir, n_rdir;
    logic [9:0]  r_rage, n_rage;

    logic [3:0]  ev;
    logic        cmd_on;
    logic [9:0]  cmd_spd;
    logic        busy;
    logic        addr_ok;
    logic [1:0]  nb_st;
    logic [13:0] nb_res;
    logic        nb_blocked;

    always_comb begin
        n_state    = r_state;
        n_tdir     = r_tdir;
        n_last     = r_last;
        n_held     = r_held;
        n_hdir     = r_hdir;
        n_rtrain   = r_rtrain;
        n_rdir     = r_rdir;
        n_rage     = r_rage;
        ev         = tbtc_pkg::EV_NONE;
        cmd_on     = 1'b0;
        cmd_spd    = 10'd0;
        nb_st      = tbtc_pkg::NB_ABSENT;
        nb_res     = 14'd0;
        nb_blocked = 1'b0;
        busy       = i_item.occupied;
        addr_ok    = i_item.loco_address >= tbtc_pkg::ADDR_KNOWN_MIN;

        if (i_item.command == tbtc_pkg::CMD_RESERVE) begin
            if ((r_state == ST_FREE || r_state == ST_RESERVED) && addr_ok) begin
                n_rtrain = i_item.loco_address;
                n_rdir   = (i_item.reserve_sens == tbtc_pkg::DIR_INVALID) ?
                           tbtc_pkg::DIR_UNKNOWN : i_item.reserve_sens;
                n_rage   = 10'd0;
                n_state  = ST_RESERVED;
            end
        end else begin
            // reservation ageing
            if (r_rtrain >= tbtc_pkg::ADDR_KNOWN_MIN && !busy) begin
                if (r_rage >= i_cfg.resv_timeout) begin
                    n_rtrain = 14'd0;
                    n_rdir   = tbtc_pkg::DIR_UNKNOWN;
                    n_rage   = 10'd0;
                    if (r_state == ST_RESERVED) begin
                        n_state = ST_FREE;
                    end
                end else begin
                    n_rage = r_rage + 10'd1;
                end
            end

            // event detection
            if (n_state == ST_RESERVED) begin
                ev = busy ? tbtc_pkg::EV_BUSY_ON : tbtc_pkg::EV_NONE;
            end else begin
                if (busy && addr_ok && r_tdir == tbtc_pkg::DIR_UNKNOWN) begin
                    if (i_item.sensor_ccw && !i_item.sensor_cw) begin
                        n_tdir = tbtc_pkg::DIR_CW;
                    end else if (i_item.sensor_cw && !i_item.sensor_ccw) begin
                        n_tdir = tbtc_pkg::DIR_CCW;
                    end else if (i_item.loco_dir == tbtc_pkg::LDIR_FWD) begin
                        n_tdir = tbtc_pkg::DIR_CW;
                    end else if (i_item.loco_dir == tbtc_pkg::LDIR_REV) begin
                        n_tdir = tbtc_pkg::DIR_CCW;
                    end
                end
                if (n_tdir == tbtc_pkg::DIR_CW) begin
                    nb_st  = i_item.next_cw_status;
                    nb_res = i_item.next_cw_reserver;
                end else if (n_tdir == tbtc_pkg::DIR_CCW) begin
                    nb_st  = i_item.next_ccw_status;
                    nb_res = i_item.next_ccw_reserver;
                end
                nb_blocked = (nb_st != tbtc_pkg::NB_ABSENT) &&
                             (nb_st >= tbtc_pkg::NB_BUSY ||
                              (nb_res >= tbtc_pkg::ADDR_KNOWN_MIN &&
                               nb_res != i_item.loco_address));

                if (n_state == ST_STOPPED && busy && addr_ok &&
                    i_item.loco_speed > tbtc_pkg::MOVING_THRESHOLD) begin
                    ev = (i_item.loco_address == r_held && i_item.loco_dir == r_hdir) ?
                         tbtc_pkg::EV_DANGEROUS : tbtc_pkg::EV_IDENTIFIED;
                end else if (!busy) begin
                    ev = tbtc_pkg::EV_BUSY_OFF;
                end else if (!addr_ok) begin
                    ev = tbtc_pkg::EV_BUSY_ON;
                end else if (nb_blocked) begin
                    if (n_tdir == tbtc_pkg::DIR_CW) begin
                        ev = i_item.sensor_ccw ? tbtc_pkg::EV_STOP :
                             (i_item.sensor_cw ? tbtc_pkg::EV_BRAKE : tbtc_pkg::EV_NEXT_BUSY);
                    end else begin
                        ev = i_item.sensor_cw ? tbtc_pkg::EV_STOP :
                             (i_item.sensor_ccw ? tbtc_pkg::EV_BRAKE : tbtc_pkg::EV_NEXT_BUSY);
                    end
                end else if (i_item.loco_speed > i_cfg.max_speed &&
                             !tbtc_pkg::close_speeds(i_item.loco_speed, i_cfg.max_speed,
                                                     i_cfg.speed_margin)) begin
                    ev = tbtc_pkg::EV_OVER_LIMIT;
                end else if (n_state == ST_LIMITED && i_item.loco_speed <= i_cfg.max_speed) begin
                    ev = tbtc_pkg::EV_SPEED_OK;
                end else begin
                    ev = tbtc_pkg::EV_IDENTIFIED;
                end
            end

            // state handling
            if (ev == tbtc_pkg::EV_BUSY_OFF) begin
                n_held  = 14'd0;
                n_hdir  = 2'd0;
                n_tdir  = tbtc_pkg::DIR_UNKNOWN;
                n_last  = tbtc_pkg::DEFAULT_TARGET;
                n_state = ST_FREE;
            end else if (!busy && n_state != ST_RESERVED) begin
                n_state = ST_FREE;
            end else begin
                if (busy && n_state == ST_FREE) begin
                    n_state = addr_ok ? ST_OCC_KNOWN : ST_OCC_UNKNOWN;
                end
                case (n_state)
                    ST_RUNNING: begin
                        if (n_tdir == tbtc_pkg::DIR_UNKNOWN) begin
                            n_state = ST_OCC_KNOWN;
                        end else if (ev == tbtc_pkg::EV_OVER_LIMIT) begin
                            if (!tbtc_pkg::close_speeds(r_last, i_cfg.max_speed,
                                                        i_cfg.speed_margin)) begin
                                cmd_on  = 1'b1;
                                cmd_spd = i_cfg.max_speed;
                                n_last  = i_cfg.max_speed;
                                n_state = ST_LIMITED;
                            end
                        end else if (ev == tbtc_pkg::EV_BRAKE) begin
                            if (!tbtc_pkg::close_speeds(r_last, i_cfg.brake_speed,
                                                        i_cfg.speed_margin)) begin
                                cmd_on  = 1'b1;
                                cmd_spd = i_cfg.brake_speed;
                                n_last  = i_cfg.brake_speed;
                            end
                            n_state = ST_SLOWING;
                        end
                    end
                    ST_SLOWING: begin
                        if (ev == tbtc_pkg::EV_STOP) begin
                            if (!tbtc_pkg::close_speeds(r_last, 10'd0, i_cfg.speed_margin)) begin
                                cmd_on  = 1'b1;
                                cmd_spd = 10'd0;
                                n_last  = 10'd0;
                            end
                            n_held  = i_item.loco_address;
                            n_hdir  = i_item.loco_dir;
                            n_state = ST_STOPPING;
                        end
                    end
                    ST_STOPPING: begin
                        if (tbtc_pkg::close_speeds(i_item.loco_speed, 10'd0,
                                                   i_cfg.speed_margin)) begin
                            n_state = ST_STOPPED;
                        end
                    end
                    ST_STOPPED: begin
                        if (ev == tbtc_pkg::EV_DANGEROUS) begin
                            cmd_on  = 1'b1;
                            cmd_spd = 10'd0;
                            n_last  = 10'd0;
                        end
                    end
                    ST_OCC_UNKNOWN: begin
                        if (ev == tbtc_pkg::EV_IDENTIFIED) begin
                            n_state = ST_OCC_KNOWN;
                        end
                    end
                    ST_OCC_KNOWN: begin
                        if (n_tdir != tbtc_pkg::DIR_UNKNOWN) begin
                            n_state = ST_RUNNING;
                        end
                    end
                    ST_LIMITED: begin
                        if (ev == tbtc_pkg::EV_SPEED_OK) begin
                            n_state = ST_RUNNING;
                        end
                    end
                    ST_RESERVED: begin
                        if (ev == tbtc_pkg::EV_BUSY_ON) begin
                            n_tdir   = n_rdir;
                            n_rtrain = 14'd0;
                            n_rdir   = tbtc_pkg::DIR_UNKNOWN;
                            n_rage   = 10'd0;
                            n_state  = ST_OCC_KNOWN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        o_result.traffic_state  = n_state;
        o_result.detected_event = ev;
        o_result.network_dir    = n_tdir;
        o_result.cmd_valid      = cmd_on;
        o_result.cmd_speed      = cmd_on ? cmd_spd : 10'd0;
        o_result.cmd_dir        = cmd_on ? i_item.loco_dir : 2'd0;
        o_result.cmd_address    = cmd_on ? i_item.loco_address : 14'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_FREE;
            r_tdir   <= tbtc_pkg::DIR_UNKNOWN;
            r_last   <= tbtc_pkg::DEFAULT_TARGET;
            r_held   <= 14'd0;
            r_hdir   <= 2'd0;
            r_rtrain <= 14'd0;
            r_rdir   <= tbtc_pkg::DIR_UNKNOWN;
            r_rage   <= 10'd0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_tdir   <= n_tdir;
            r_last   <= n_last;
            r_held   <= n_held;
            r_hdir   <= n_hdir;
            r_rtrain <= n_rtrain;
            r_rdir   <= n_rdir;
            r_rage   <= n_rage;
        end
    end

    // a reserved block always has a known reserving train
    a_resv_has_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RESERVED |-> r_rtrain >= tbtc_pkg::ADDR_KNOWN_MIN)
        else $error("reserved block without reserving train");

    // a held train exists only while stopping or stopped
    a_held_only_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 14'd0 |-> (r_state == ST_STOPPING || r_state == ST_STOPPED))
        else $error("held train outside stop states");

    // moving states need a known travel direction
    a_moving_has_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUNNING || r_state == ST_LIMITED || r_state == ST_SLOWING ||
         r_state == ST_STOPPING || r_state == ST_STOPPED) |-> r_tdir != tbtc_pkg::DIR_UNKNOWN)
        else $error("moving state with unknown travel direction");

endmodule

### design/track_block_traffic_controller.sv
// ----------------------------------------------------------------------------
// track_block_traffic_controller
// Traffic supervision of one track block: one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat (periodic tick or reservation) yields exactly one result
// beat. An input beat is registered, evaluated against the block state and
// the result is registered, so one beat is taken every cycle while the output
// is not stalled. The output register decouples the sides: while a result
// waits, one more beat is still taken into the empty input register; with
// both registers full the input stalls until the waiting result is taken.
// Configuration writes take effect on the next beat; the user must make them
// only while no beat is in flight, and the block itself does not enforce it.
module track_block_traffic_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [9:0]       i_cfg_data,
    tbtc_in_if.sink          i_in,
    tbtc_out_if.source       o_out
);

    tbtc_pkg::t_cfg      r_cfg;
    logic                r_in_valid;
    tbtc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    tbtc_pkg::t_out_item r_out;
    tbtc_pkg::t_out_item result;
    logic                advance;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed    <= tbtc_pkg::RST_MAX_SPEED;
            r_cfg.brake_speed  <= tbtc_pkg::RST_BRAKE_SPEED;
            r_cfg.speed_margin <= tbtc_pkg::RST_SPEED_TOL;
            r_cfg.resv_timeout <= tbtc_pkg::RST_RESV_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tbtc_pkg::CFG_MAX_SPEED:    r_cfg.max_speed    <= i_cfg_data;
                tbtc_pkg::CFG_BRAKE_SPEED:  r_cfg.brake_speed  <= i_cfg_data;
                tbtc_pkg::CFG_SPEED_TOL:    r_cfg.speed_margin <= i_cfg_data[7:0];
                tbtc_pkg::CFG_RESV_TIMEOUT: r_cfg.resv_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    tbtc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_in_valid && advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

endmodule

### test/track_block_traffic_controller_tb.sv
// ----------------------------------------------------------------------------
// track_block_traffic_controller_tb
// Self-checking bench for the track block traffic controller.
// ----------------------------------------------------------------------------
// A short scripted sequence walks a train through reservation, expiry, entry,
// braking, stopping, a dangerous restart and departure. Random train passes
// follow, under several register settings and with random valid/ready idling.
// Every result beat is checked against the in-bench block model or a script row.
module track_block_traffic_controller_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 220;
    localparam logic [1:0] NB_FREE = 2'd1;

    typedef enum logic [3:0] {
        TS_FREE, TS_RESERVED, TS_OCC_UNKNOWN, TS_OCC_KNOWN, TS_RUNNING,
        TS_LIMITED, TS_SLOWING, TS_STOPPING, TS_STOPPED
    } t_traffic_state;

    typedef struct {
        tbtc_pkg::t_in_item  item;
        int                  reps;
        bit                  typed;
        tbtc_pkg::t_out_item want;
    } t_script_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    tbtc_in_if  in_ch();
    tbtc_out_if out_ch();

    track_block_traffic_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // block model state and its copy of the registers
    t_traffic_state blk_state;
    logic [1:0]     travel;
    logic [9:0]     target_speed;
    logic [13:0]    held_addr;
    logic [1:0]     held_ldir;
    logic [13:0]    resv_addr;
    logic [1:0]     resv_sens;
    logic [9:0]     resv_ticks;
    logic [9:0]     lim_speed;
    logic [9:0]     slow_speed;
    logic [7:0]     tol;
    logic [9:0]     resv_limit;
    bit             cmd_on;
    logic [9:0]     cmd_spd;

    tbtc_pkg::t_out_item due_reports[$];
    t_script_row         script[$];
    int                  fail_count;
    int                  cycles;
    int                  gap_pct;
    int                  stall_pct;
    int                  beats_sent;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit speeds_match(input logic [9:0] a, input logic [9:0] b);
        logic [9:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= {2'b00, tol};
    endfunction

    function automatic void request_speed(input logic [9:0] target);
        if (!speeds_match(target_speed, target)) begin
            cmd_on       = 1'b1;
            cmd_spd      = target;
            target_speed = target;
        end
    endfunction

    function automatic tbtc_pkg::t_out_item advance_block(input tbtc_pkg::t_in_item it);
        tbtc_pkg::t_out_item r;
        logic [3:0]          ev;
        logic [1:0]          nst;
        logic [13:0]         nres;
        bit                  known;
        bit                  busy;
        cmd_on = 1'b0;
        cmd_spd = '0;
        ev = tbtc_pkg::EV_NONE;
        busy = it.occupied;
        known = it.loco_address >= tbtc_pkg::ADDR_KNOWN_MIN;
        if (it.command == tbtc_pkg::CMD_RESERVE) begin
            if ((blk_state == TS_FREE || blk_state == TS_RESERVED) && known) begin
                resv_addr  = it.loco_address;
                resv_sens  = (it.reserve_sens == tbtc_pkg::DIR_INVALID) ?
                             tbtc_pkg::DIR_UNKNOWN : it.reserve_sens;
                resv_ticks = '0;
                blk_state  = TS_RESERVED;
            end
        end else begin
            if (resv_addr >= tbtc_pkg::ADDR_KNOWN_MIN && !busy) begin
                if (resv_ticks >= resv_limit) begin
                    resv_addr  = '0;
                    resv_sens  = tbtc_pkg::DIR_UNKNOWN;
                    resv_ticks = '0;
                    if (blk_state == TS_RESERVED) blk_state = TS_FREE;
                end else begin
                    resv_ticks = resv_ticks + 10'd1;
                end
            end

            if (blk_state == TS_RESERVED) begin
                ev = busy ? tbtc_pkg::EV_BUSY_ON : tbtc_pkg::EV_NONE;
            end else begin
                if (busy && known && travel == tbtc_pkg::DIR_UNKNOWN) begin
                    if (it.sensor_ccw && !it.sensor_cw) travel = tbtc_pkg::DIR_CW;
                    else if (it.sensor_cw && !it.sensor_ccw) travel = tbtc_pkg::DIR_CCW;
                    else if (it.loco_dir == tbtc_pkg::LDIR_FWD) travel = tbtc_pkg::DIR_CW;
                    else if (it.loco_dir == tbtc_pkg::LDIR_REV) travel = tbtc_pkg::DIR_CCW;
                end
                if (blk_state == TS_STOPPED && busy && known
                        && it.loco_speed > tbtc_pkg::MOVING_THRESHOLD) begin
                    ev = (it.loco_address == held_addr && it.loco_dir == held_ldir)
                         ? tbtc_pkg::EV_DANGEROUS : tbtc_pkg::EV_IDENTIFIED;
                end else if (!busy) begin
                    ev = tbtc_pkg::EV_BUSY_OFF;
                end else if (!known) begin
                    ev = tbtc_pkg::EV_BUSY_ON;
                end else begin
                    nst = tbtc_pkg::NB_ABSENT;
                    nres = '0;
                    if (travel == tbtc_pkg::DIR_CW) begin
                        nst = it.next_cw_status;
                        nres = it.next_cw_reserver;
                    end else if (travel == tbtc_pkg::DIR_CCW) begin
                        nst = it.next_ccw_status;
                        nres = it.next_ccw_reserver;
                    end
                    if (nst != tbtc_pkg::NB_ABSENT && (nst >= tbtc_pkg::NB_BUSY
                            || (nres >= tbtc_pkg::ADDR_KNOWN_MIN
                                && nres != it.loco_address))) begin
                        if (travel == tbtc_pkg::DIR_CW)
                            ev = it.sensor_ccw ? tbtc_pkg::EV_STOP :
                                 (it.sensor_cw ? tbtc_pkg::EV_BRAKE : tbtc_pkg::EV_NEXT_BUSY);
                        else
                            ev = it.sensor_cw ? tbtc_pkg::EV_STOP :
                                 (it.sensor_ccw ? tbtc_pkg::EV_BRAKE : tbtc_pkg::EV_NEXT_BUSY);
                    end else if (it.loco_speed > lim_speed
                            && !speeds_match(it.loco_speed, lim_speed)) begin
                        ev = tbtc_pkg::EV_OVER_LIMIT;
                    end else if (blk_state == TS_LIMITED && it.loco_speed <= lim_speed) begin
                        ev = tbtc_pkg::EV_SPEED_OK;
                    end else begin
                        ev = tbtc_pkg::EV_IDENTIFIED;
                    end
                end
            end

            if (ev == tbtc_pkg::EV_BUSY_OFF) begin
                held_addr    = '0;
                held_ldir    = '0;
                travel       = tbtc_pkg::DIR_UNKNOWN;
                target_speed = tbtc_pkg::DEFAULT_TARGET;
                blk_state    = TS_FREE;
            end else if (!busy && blk_state != TS_RESERVED) begin
                blk_state = TS_FREE;
            end else begin
                if (busy && blk_state == TS_FREE)
                    blk_state = known ? TS_OCC_KNOWN : TS_OCC_UNKNOWN;
                case (blk_state)
                    TS_RUNNING: begin
                        if (travel == tbtc_pkg::DIR_UNKNOWN) begin
                            blk_state = TS_OCC_KNOWN;
                        end else if (ev == tbtc_pkg::EV_OVER_LIMIT) begin
                            request_speed(lim_speed);
                            if (cmd_on) blk_state = TS_LIMITED;
                        end else if (ev == tbtc_pkg::EV_BRAKE) begin
                            request_speed(slow_speed);
                            blk_state = TS_SLOWING;
                        end
                    end
                    TS_SLOWING: begin
                        if (ev == tbtc_pkg::EV_STOP) begin
                            request_speed('0);
                            held_addr = it.loco_address;
                            held_ldir = it.loco_dir;
                            blk_state = TS_STOPPING;
                        end
                    end
                    TS_STOPPING: begin
                        if (speeds_match(it.loco_speed, 10'd0)) blk_state = TS_STOPPED;
                    end
                    TS_STOPPED: begin
                        // forced stop on a restart toward the blocked side
                        if (ev == tbtc_pkg::EV_DANGEROUS) begin
                            cmd_on       = 1'b1;
                            cmd_spd      = '0;
                            target_speed = '0;
                        end
                    end
                    TS_OCC_UNKNOWN: begin
                        if (ev == tbtc_pkg::EV_IDENTIFIED) blk_state = TS_OCC_KNOWN;
                    end
                    TS_OCC_KNOWN: begin
                        if (travel != tbtc_pkg::DIR_UNKNOWN) blk_state = TS_RUNNING;
                    end
                    TS_LIMITED: begin
                        if (ev == tbtc_pkg::EV_SPEED_OK) blk_state = TS_RUNNING;
                    end
                    TS_RESERVED: begin
                        if (ev == tbtc_pkg::EV_BUSY_ON) begin
                            travel     = resv_sens;
                            resv_addr  = '0;
                            resv_sens  = tbtc_pkg::DIR_UNKNOWN;
                            resv_ticks = '0;
                            blk_state  = TS_OCC_KNOWN;
                        end
                    end
                    default: ;
                endcase
            end
        end

        r.traffic_state  = blk_state;
        r.detected_event = ev;
        r.network_dir    = travel;
        r.cmd_valid      = cmd_on;
        r.cmd_speed      = cmd_on ? cmd_spd : '0;
        r.cmd_dir        = cmd_on ? it.loco_dir : '0;
        r.cmd_address    = cmd_on ? it.loco_address : '0;
        return r;
    endfunction

    function automatic tbtc_pkg::t_in_item tick_item(input bit occ, input int addr,
                                                     input int spd, input int ldir,
                                                     input bit scw, input bit sccw,
                                                     input int cw_st, input int cw_res,
                                                     input int ccw_st, input int ccw_res);
        tbtc_pkg::t_in_item it;
        it = '0;
        it.command           = tbtc_pkg::CMD_TICK;
        it.occupied          = occ;
        it.loco_address      = 14'(addr);
        it.loco_speed        = 10'(spd);
        it.loco_dir          = 2'(ldir);
        it.sensor_cw         = scw;
        it.sensor_ccw        = sccw;
        it.next_cw_status    = 2'(cw_st);
        it.next_cw_reserver  = 14'(cw_res);
        it.next_ccw_status   = 2'(ccw_st);
        it.next_ccw_reserver = 14'(ccw_res);
        return it;
    endfunction

    function automatic tbtc_pkg::t_in_item resv_item(input int addr, input int sens);
        tbtc_pkg::t_in_item it;
        it = '0;
        it.command      = tbtc_pkg::CMD_RESERVE;
        it.loco_address = 14'(addr);
        it.reserve_sens = 2'(sens);
        return it;
    endfunction

    function automatic tbtc_pkg::t_out_item outcome(input t_traffic_state st,
                                                    input logic [3:0] ev,
                                                    input logic [1:0] dir);
        tbtc_pkg::t_out_item r;
        r = '0;
        r.traffic_state  = st;
        r.detected_event = ev;
        r.network_dir    = dir;
        return r;
    endfunction

    function automatic void add_row(input tbtc_pkg::t_in_item it, input int reps,
                                    input bit typed = 1'b0,
                                    input tbtc_pkg::t_out_item want = '0);
        script.push_back('{it, reps, typed, want});
    endfunction

    function automatic tbtc_pkg::t_in_item random_tick();
        tbtc_pkg::t_in_item it;
        int v;
        it[31:0] = $urandom;
        it[63:32] = $urandom;
        it.command = tbtc_pkg::CMD_TICK;
        it.sensor_cw = ($urandom_range(0, 3) == 0);
        it.sensor_ccw = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0: it.loco_speed = 10'($urandom_range(0, 20));
            1: it.loco_speed = 10'($urandom_range(21, 1023));
            2: begin
                v = int'(lim_speed) + int'($urandom_range(0, 60)) - 30;
                it.loco_speed = 10'((v < 0) ? 0 : ((v > 1023) ? 1023 : v));
            end
            default: it.loco_speed = 10'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0: it.next_cw_reserver = 14'($urandom_range(0, 1));
            1: it.next_ccw_reserver = 14'($urandom_range(0, 1));
            default: ;
        endcase
        return it;
    endfunction

    // drive one beat, wait for its handshake, then record the expected report
    task automatic offer_beat(input tbtc_pkg::t_in_item it, input bit typed = 1'b0,
                              input tbtc_pkg::t_out_item want = '0);
        tbtc_pkg::t_out_item predicted;
        while ($urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = advance_block(it);
        due_reports.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input tbtc_pkg::t_cfg c);
        drain();
        write_reg(tbtc_pkg::CFG_MAX_SPEED, c.max_speed);
        write_reg(tbtc_pkg::CFG_BRAKE_SPEED, c.brake_speed);
        write_reg(tbtc_pkg::CFG_SPEED_TOL, {2'b00, c.speed_margin});
        write_reg(tbtc_pkg::CFG_RESV_TIMEOUT, c.resv_timeout);
        i_cfg_we <= 1'b0;
        lim_speed  = c.max_speed;
        slow_speed = c.brake_speed;
        tol        = c.speed_margin;
        resv_limit = c.resv_timeout;
    endtask

    // one train: optional reservation, a quiet spell, occupancy, departure
    task automatic run_train_pass();
        tbtc_pkg::t_in_item it;
        logic [13:0]        train;
        logic [1:0]         ldir;
        int                 len;
        int                 quiet;
        train = ($urandom_range(0, 9) != 0) ? 14'($urandom_range(2, 16383))
                                             : 14'($urandom_range(0, 1));
        ldir = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) != 0) begin
            it = resv_item(($urandom_range(0, 4) != 0) ? int'(train)
                                                       : int'($urandom_range(0, 16383)),
                           int'($urandom_range(0, 3)));
            offer_beat(it);
        end
        quiet = int'($urandom_range(0, (resv_limit < 30) ? int'(resv_limit) + 2 : 5));
        repeat (quiet) begin
            it = random_tick();
            it.occupied = 1'b0;
            offer_beat(it);
        end
        len = int'($urandom_range(4, 30));
        repeat (len) begin
            it = random_tick();
            if ($urandom_range(0, 9) == 0) begin
                it = resv_item(int'($urandom_range(0, 16383)), int'($urandom_range(0, 3)));
            end else begin
                it.occupied = ($urandom_range(0, 19) != 0);
                if ($urandom_range(0, 9) != 0) it.loco_address = train;
                if ($urandom_range(0, 6) != 0) it.loco_dir = ldir;
                if ($urandom_range(0, 2) == 0) it.next_cw_reserver = train;
                if ($urandom_range(0, 2) == 0) it.next_ccw_reserver = train;
            end
            offer_beat(it);
        end
        it = random_tick();
        it.occupied = 1'b0;
        offer_beat(it);
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        tbtc_pkg::t_out_item exp_r;
        tbtc_pkg::t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (due_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: st=%0d ev=%0d dir=%0d",
                             got.traffic_state, got.detected_event, got.network_dir);
            end else begin
                exp_r = due_reports.pop_front();
                if (got.traffic_state !== exp_r.traffic_state
                        || got.detected_event !== exp_r.detected_event
                        || got.network_dir !== exp_r.network_dir
                        || got.cmd_valid !== exp_r.cmd_valid
                        || got.cmd_speed !== exp_r.cmd_speed
                        || got.cmd_dir !== exp_r.cmd_dir
                        || got.cmd_address !== exp_r.cmd_address) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch exp: st=%0d ev=%0d dir=%0d cmd=%0d spd=%0d cdir=%0d addr=%0d",
                                 exp_r.traffic_state, exp_r.detected_event, exp_r.network_dir,
                                 exp_r.cmd_valid, exp_r.cmd_speed, exp_r.cmd_dir,
                                 exp_r.cmd_address);
                        $display("         got: st=%0d ev=%0d dir=%0d cmd=%0d spd=%0d cdir=%0d addr=%0d",
                                 got.traffic_state, got.detected_event, got.network_dir,
                                 got.cmd_valid, got.cmd_speed, got.cmd_dir, got.cmd_address);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        tbtc_pkg::t_cfg phase_cfg;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        fail_count   = 0;
        cycles       = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        beats_sent   = 0;

        blk_state    = TS_FREE;
        travel       = tbtc_pkg::DIR_UNKNOWN;
        target_speed = tbtc_pkg::DEFAULT_TARGET;
        held_addr    = '0;
        held_ldir    = '0;
        resv_addr    = '0;
        resv_sens    = tbtc_pkg::DIR_UNKNOWN;
        resv_ticks   = '0;
        lim_speed    = tbtc_pkg::RST_MAX_SPEED;
        slow_speed   = tbtc_pkg::RST_BRAKE_SPEED;
        tol          = tbtc_pkg::RST_SPEED_TOL;
        resv_limit   = tbtc_pkg::RST_RESV_TIMEOUT;

        // reservation, expiry, entry, brake, stop, dangerous restart, departure
        add_row(tick_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1,
                outcome(TS_FREE, tbtc_pkg::EV_BUSY_OFF, tbtc_pkg::DIR_UNKNOWN));
        add_row(resv_item(16383, tbtc_pkg::DIR_INVALID), 1, 1'b1,
                outcome(TS_RESERVED, tbtc_pkg::EV_NONE, tbtc_pkg::DIR_UNKNOWN));
        add_row(resv_item(1, tbtc_pkg::DIR_CW), 1, 1'b1,
                outcome(TS_RESERVED, tbtc_pkg::EV_NONE, tbtc_pkg::DIR_UNKNOWN));
        add_row(tick_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 16);
        add_row(resv_item(2, tbtc_pkg::DIR_CCW), 1, 1'b1,
                outcome(TS_RESERVED, tbtc_pkg::EV_NONE, tbtc_pkg::DIR_UNKNOWN));
        add_row(tick_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1,
                outcome(TS_OCC_KNOWN, tbtc_pkg::EV_BUSY_ON, tbtc_pkg::DIR_CCW));
        add_row(tick_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row(tick_item(1, 500, 300, tbtc_pkg::LDIR_FWD, 0, 1, NB_FREE, 0, 3, 0), 1);
        add_row(tick_item(1, 500, 200, tbtc_pkg::LDIR_FWD, 1, 0, NB_FREE, 0, 3, 0), 1);
        add_row(tick_item(1, 500, 20, tbtc_pkg::LDIR_FWD, 0, 0, NB_FREE, 0, 3, 0), 1);
        add_row(tick_item(1, 500, 1023, tbtc_pkg::LDIR_FWD, 0, 0, NB_FREE, 0, 3, 0), 1);
        add_row(tick_item(1, 16383, 21, tbtc_pkg::DIR_INVALID, 0, 0, NB_FREE, 0, 3, 16383), 1);
        add_row(tick_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1,
                outcome(TS_FREE, tbtc_pkg::EV_BUSY_OFF, tbtc_pkg::DIR_UNKNOWN));
        add_row(tick_item(1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row(tick_item(1, 9, 0, tbtc_pkg::DIR_INVALID, 0, 0, 0, 0, 0, 0), 1);
        add_row(tick_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row(tick_item(1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row(tick_item(1, 300, 500, 0, 1, 0, tbtc_pkg::NB_ABSENT, 0,
                          tbtc_pkg::NB_ABSENT, 0), 1);
        add_row(tick_item(1, 300, 500, 0, 0, 0, NB_FREE, 0, NB_FREE, 16383), 1);
        add_row(tick_item(1, 300, 1023, 0, 0, 0, NB_FREE, 0, NB_FREE, 300), 1);
        add_row(resv_item(9, tbtc_pkg::DIR_CW), 1);
        add_row(tick_item(0, 16383, 1023, 3, 1, 1, 3, 16383, 3, 16383), 1);
        add_row(tick_item(1, 7, 0, tbtc_pkg::LDIR_FWD, 1, 1, 3, 16383, 0, 0), 1);
        add_row(tick_item(1, 7, 0, tbtc_pkg::LDIR_FWD, 0, 0, NB_FREE, 16383, 0, 0), 1);
        add_row(tick_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            repeat (script[i].reps) offer_beat(script[i].item, script[i].typed, script[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: phase_cfg = '{max_speed: 10'd0, brake_speed: 10'd0,
                                 speed_margin: 8'd0, resv_timeout: 10'd1};
                2: phase_cfg = '{max_speed: 10'd1023, brake_speed: 10'd1023,
                                 speed_margin: 8'd255, resv_timeout: 10'd1023};
                5: phase_cfg = '{max_speed: 10'd500, brake_speed: 10'd300,
                                 speed_margin: 8'd0, resv_timeout: 10'd3};
                0, 7: phase_cfg = '{max_speed: tbtc_pkg::RST_MAX_SPEED,
                                    brake_speed: tbtc_pkg::RST_BRAKE_SPEED,
                                    speed_margin: tbtc_pkg::RST_SPEED_TOL,
                                    resv_timeout: tbtc_pkg::RST_RESV_TIMEOUT};
                default: begin
                    phase_cfg.max_speed    = 10'($urandom_range(50, 1023));
                    phase_cfg.brake_speed  = 10'($urandom_range(0, 400));
                    phase_cfg.speed_margin = 8'($urandom_range(0, 60));
                    phase_cfg.resv_timeout = 10'($urandom_range(1, 40));
                end
            endcase
            apply_config(phase_cfg);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 63; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 63; end
                default: begin gap_pct = 37; stall_pct = 37; end
            endcase
            beats_sent = 0;
            while (beats_sent < PHASE_BEATS) run_train_pass();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && due_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
